>>> sv/assert_macros.svh
// Assertion macros for the constant fraction discriminator checkers.
// Included by checker files; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cfd assertion failed");

// antecedent implies consequent in the next cycle
`define CFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cfd assertion failed");

`endif

>>> sv/cfd_pkg.sv
// Shared constants and types of the constant fraction discriminator.
// Used by the configuration, divider and top-level RTL modules and the testbench; no dependencies.
`default_nettype none
package cfd_pkg;
	localparam int MAX_DELAY       = 16;
	localparam int MAX_HALF_WINDOW = 8;
	localparam int MAX_SAMPLES     = 4096;

	localparam int RAW_AW    = $clog2(2 * MAX_HALF_WINDOW + 1);
	localparam int RAW_DEPTH = 1 << RAW_AW;
	localparam int SM_AW     = $clog2(MAX_DELAY + 1);
	localparam int SM_DEPTH  = 1 << SM_AW;
	localparam int CNT_W     = $clog2(MAX_SAMPLES) + 1;
	localparam int IDX_W     = CNT_W + 1;

	localparam int SMP_W   = 16;
	localparam int ATT_W   = 7;
	localparam int DLY_W   = 5;
	localparam int HW_W    = 4;
	localparam int STEP_W  = 11;
	localparam int TIME_W  = 22;
	localparam int REM_W   = 5;
	localparam int NUM_W   = 28;
	localparam int DEN_W   = 17;
	localparam int QCNT_W  = $clog2(NUM_W + 1);

	localparam logic [ATT_W-1:0]  ATT_RST  = 7'd24;
	localparam logic [DLY_W-1:0]  DLY_RST  = 5'd8;
	localparam logic [HW_W-1:0]   HW_RST   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RST = 11'd256;

	localparam logic [1:0] REG_ATT  = 2'd0;
	localparam logic [1:0] REG_DLY  = 2'd1;
	localparam logic [1:0] REG_HW   = 2'd2;
	localparam logic [1:0] REG_STEP = 2'd3;

	typedef struct packed {
		logic [ATT_W-1:0]  att;
		logic [DLY_W-1:0]  dly;
		logic [HW_W-1:0]   hw;
		logic [STEP_W-1:0] steps;
	} cfg_t;
endpackage
`default_nettype wire

>>> sv/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cfd_ram #(
	parameter int W = 16,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/cfd_cfg.sv
// Configuration registers behind the APB-style port, with clamped delay and half-window views.
// Depends on cfd_pkg.
`default_nettype none
module cfd_cfg import cfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);
	logic [ATT_W-1:0]  att_q;
	logic [DLY_W-1:0]  dly_q;
	logic [HW_W-1:0]   hw_q;
	logic [STEP_W-1:0] steps_q;
	logic              wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q   <= ATT_RST;
			dly_q   <= DLY_RST;
			hw_q    <= HW_RST;
			steps_q <= STEP_RST;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_ATT:  att_q   <= pwdata[ATT_W-1:0];
				REG_DLY:  dly_q   <= pwdata[DLY_W-1:0];
				REG_HW:   hw_q    <= pwdata[HW_W-1:0];
				REG_STEP: steps_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ATT:  prdata = {{(32-ATT_W){1'b0}}, att_q};
			REG_DLY:  prdata = {{(32-DLY_W){1'b0}}, dly_q};
			REG_HW:   prdata = {{(32-HW_W){1'b0}}, hw_q};
			REG_STEP: prdata = {{(32-STEP_W){1'b0}}, steps_q};
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.att   = att_q;
		cfg.steps = steps_q;
		cfg.dly   = (dly_q > DLY_W'(MAX_DELAY)) ? DLY_W'(MAX_DELAY) : dly_q;
		cfg.hw    = (hw_q > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : hw_q;
	end
endmodule
`default_nettype wire

>>> sv/cfd_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on cfd_pkg.
`default_nettype none
module cfd_div import cfd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic signed [DEN_W-1:0] den,
	output logic                         done,
	output logic signed [NUM_W-1:0]      quo
);
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  dmag_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DEN_W:0]    shifted;
	logic              ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge = shifted >= {1'b0, dmag_q};
	assign done = done_q;
	assign quo = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dmag_q <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(shifted - {1'b0, dmag_q}) : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

>>> sv/digital_cfd_timing.sv
// Each request passes the write, smoothing-sum (half window h > 0 only), push and monitor states
// in turn; an armed crossing adds a serial division, one quotient bit per divider step.
// A new request is accepted only once the previous one has finished, with fewer states while
// the history fills. A result held by the receiver stalls the input.
// Reset clears the control registers and per-waveform state; history RAMs are qualified by counts.
`default_nettype none
module digital_cfd_timing import cfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // sample[15:0], remainder_bits[20:16], zero pad
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // cfd_time[26:0], zero pad
	output logic      [0:0]  m_axis_tuser,  // crossing_found[0]
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_WRITE = 8'b00000010,
		ST_SUM   = 8'b00000100,
		ST_SUMW  = 8'b00001000,
		ST_PUSH  = 8'b00010000,
		ST_MON   = 8'b00100000,
		ST_DIV   = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	cfg_t cfg;
	state_t state_q;

	logic [SMP_W-1:0]  smp_q;
	logic              last_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SM_AW:0]    smcnt_q;
	logic [RAW_AW-1:0] wptr_q;
	logic [SM_AW-1:0]  sptr_q;
	logic [RAW_AW-1:0] idx_q;
	logic              rd_vld_s1;
	logic [SMP_W-1:0]  acc_q;
	logic signed [IDX_W-1:0] j_q;
	logic signed [IDX_W-1:0] k_q;
	logic              d0_q;
	logic              sd_ok_q;
	logic signed [SMP_W-1:0] pm_q;
	logic signed [SMP_W-1:0] max_q;
	logic              armed_q;
	logic              found_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] base_q;
	logic              out_vld_q;
	logic [31:0]       out_data_q;
	logic              out_found_q;

	logic              raw_we;
	logic [RAW_AW-1:0] raw_waddr;
	logic [RAW_AW-1:0] raw_raddr;
	logic [SMP_W-1:0]  raw_rdata;
	logic              sm_we;
	logic [SM_AW-1:0]  sm_waddr;
	logic [SM_AW-1:0]  sm_raddr;
	logic [SMP_W-1:0]  sm_rdata;

	logic              div_start;
	logic signed [NUM_W-1:0] div_num;
	logic signed [DEN_W-1:0] div_den;
	logic              div_done;
	logic signed [NUM_W-1:0] div_quo;

	logic signed [IDX_W-1:0] j_new;
	logic signed [IDX_W-1:0] k_new;
	logic signed [SMP_W-1:0] s0;
	logic signed [SMP_W-1:0] sd;
	logic signed [24:0]      mdiff;
	logic signed [24:0]      madj;
	logic signed [SMP_W-1:0] m;
	logic signed [DEN_W-1:0] den;
	logic [CNT_W-2:0]        km1;
	logic [TIME_W-1:0]       base;
	logic                    in_acc;
	logic                    out_free;

	function automatic logic [IDX_W-2:0] cfg_cnt_ext(input logic [CNT_W-1:0] c);
		cfg_cnt_ext = (IDX_W-1)'(c);
	endfunction

	cfd_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	cfd_ram #(.W(SMP_W), .D(RAW_DEPTH)) u_raw (
		.clk, .we(raw_we), .waddr(raw_waddr), .wdata(smp_q),
		.raddr(raw_raddr), .rdata(raw_rdata)
	);

	cfd_ram #(.W(SMP_W), .D(SM_DEPTH)) u_sm (
		.clk, .we(sm_we), .waddr(sm_waddr), .wdata(acc_q),
		.raddr(sm_raddr), .rdata(sm_rdata)
	);

	cfd_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	assign s_axis_tready = state_q == ST_IDLE;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_found_q;
	assign m_axis_tlast = 1'b1;

	assign raw_we    = state_q == ST_WRITE;
	assign raw_waddr = wptr_q + 1'b1;
	assign raw_raddr = wptr_q - idx_q;
	assign sm_we     = state_q == ST_PUSH;
	assign sm_waddr  = sptr_q + 1'b1;
	assign sm_raddr  = sptr_q + 1'b1 - cfg.dly[SM_AW-1:0];

	assign j_new = $signed({1'b0, cfg_cnt_ext(cnt_q)}) - $signed(IDX_W'({cfg.hw, 1'b0}));
	assign k_new = j_q - $signed(IDX_W'(cfg.dly));

	assign s0 = $signed(acc_q);
	assign sd = d0_q ? $signed(acc_q) : (sd_ok_q ? $signed(sm_rdata) : '0);
	assign mdiff = $signed({1'b0, cfg.att}) * s0 - ($signed(25'(sd)) <<< 6);
	assign madj = mdiff[24] ? mdiff + 25'sd63 : mdiff;
	assign m = $signed(madj[21:6]);
	assign den = $signed(DEN_W'(pm_q)) - $signed(DEN_W'(m));
	assign km1 = k_q[CNT_W-2:0] - 1'b1;
	assign base = TIME_W'(km1 * cfg.steps);

	assign div_start = state_q == ST_MON && !(m > max_q) && k_q > 0 && armed_q
		&& m < 0 && den != 0;
	assign div_num = $signed(NUM_W'(pm_q)) * $signed({1'b0, cfg.steps});
	assign div_den = den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			smcnt_q   <= '0;
			wptr_q    <= '0;
			sptr_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			pm_q      <= '0;
			max_q     <= '0;
			armed_q   <= 1'b0;
			found_q   <= 1'b0;
			time_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && last_q && out_free)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
			rd_vld_s1 <= state_q == ST_SUM;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= (cnt_q < CNT_W'(MAX_SAMPLES)) ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: begin
					cnt_q  <= cnt_q + 1'b1;
					wptr_q <= wptr_q + 1'b1;
					idx_q  <= '0;
					if (j_new < 0)
						state_q <= ST_DONE;
					else if (cfg.hw == '0)
						state_q <= ST_PUSH;
					else
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (idx_q == RAW_AW'({cfg.hw, 1'b0}))
						state_q <= ST_SUMW;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_SUMW: state_q <= ST_PUSH;
				ST_PUSH: begin
					sptr_q <= sptr_q + 1'b1;
					if (smcnt_q != (SM_AW+1)'(SM_DEPTH))
						smcnt_q <= smcnt_q + 1'b1;
					state_q <= (k_new < 0) ? ST_DONE : ST_MON;
				end
				ST_MON: begin
					pm_q <= m;
					if (m > max_q) begin
						armed_q <= 1'b1;
						max_q   <= m;
						state_q <= ST_DONE;
					end else if (k_q > 0 && armed_q && m < 0) begin
						armed_q <= 1'b0;
						found_q <= 1'b1;
						if (den == 0) begin
							time_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						time_q  <= base_q + div_quo[TIME_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						cnt_q     <= '0;
						smcnt_q   <= '0;
						pm_q      <= '0;
						max_q     <= '0;
						armed_q   <= 1'b0;
						found_q   <= 1'b0;
						time_q    <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= s_axis_tdata[SMP_W-1:0];
			rem_q  <= s_axis_tdata[SMP_W +: REM_W];
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_WRITE) begin
			j_q   <= j_new;
			acc_q <= (cfg.hw == '0) ? smp_q : '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + raw_rdata;
		end
		if (state_q == ST_PUSH) begin
			k_q     <= k_new;
			d0_q    <= cfg.dly == '0;
			sd_ok_q <= (SM_AW+1)'(cfg.dly) <= smcnt_q;
		end
		if (state_q == ST_MON)
			base_q <= base;
		if (state_q == ST_DONE && last_q && out_free) begin
			out_data_q  <= {5'd0, rem_q, found_q ? time_q : {TIME_W{1'b0}}};
			out_found_q <= found_q;
		end
	end
endmodule
`default_nettype wire

>>> sv/cfd_chk.sv
// Port-level checker for digital_cfd_timing, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cfd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);
	`CFD_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`CFD_ASSERT_NOW(a_no_cross_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata[21:0] == 22'd0)
	`CFD_ASSERT_NOW(a_rise_after_work, clk, arst_n, $rose(m_axis_tvalid),
		!$past(s_axis_tvalid && s_axis_tready))
	`CFD_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready)
endmodule

bind digital_cfd_timing cfd_chk u_cfd_chk (.*);
`default_nettype wire

>>> tb/sv/digital_cfd_timing_tb.sv
// Self-checking testbench for digital_cfd_timing: streams waveforms with pulses,
// noise and extremes through the sample port and checks each timing result.
// Depends on cfd_pkg and the digital_cfd_timing RTL.
`default_nettype none
module digital_cfd_timing_tb;
	import cfd_pkg::*;

	typedef struct packed {
		logic [26:0] cfd_time;
		logic        found;
	} cfd_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // sample[15:0], remainder_bits[20:16], zero pad
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // cfd_time[26:0], zero pad
	logic [0:0]  m_axis_tuser;       // crossing_found[0]
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	digital_cfd_timing u_top (.*);

	always #6 clk = ~clk;

	// discriminator model state
	int          att_num, dly_num, hw_num, step_num;
	logic [15:0] raw_hist [17];
	logic [15:0] smooth_hist [17];
	int          n_samples;
	int          prev_mon, mon_max;
	bit          armed, found;
	logic [21:0] cross_time;

	cfd_result_t pending_results [$];
	int          errors = 0;
	int          send_idle_pct = 0, recv_idle_pct = 0;
	int          hold_cycles = 0;

	function automatic void clear_waveform();
		foreach (raw_hist[i]) raw_hist[i] = '0;
		foreach (smooth_hist[i]) smooth_hist[i] = '0;
		n_samples = 0;
		prev_mon = 0;
		mon_max = 0;
		armed = 1'b0;
		found = 1'b0;
		cross_time = '0;
	endfunction

	function automatic void take_sample(logic [15:0] smp);
		int h, d;
		longint cnt, j, k, acc, mv, den, t;
		logic [15:0] sm;
		int m;
		h = hw_num > MAX_HALF_WINDOW ? MAX_HALF_WINDOW : hw_num;
		d = dly_num > MAX_DELAY ? MAX_DELAY : dly_num;
		cnt = n_samples;
		n_samples++;
		for (int i = 16; i > 0; i--) raw_hist[i] = raw_hist[i-1];
		raw_hist[0] = smp;
		j = cnt - 2 * h;
		if (j < 0) return;
		if (h == 0) begin
			sm = smp;
		end else begin
			acc = 0;
			for (int i = 0; i <= 2 * h; i++) acc += $signed(raw_hist[i]);
			sm = acc[15:0];
		end
		for (int i = 16; i > 0; i--) smooth_hist[i] = smooth_hist[i-1];
		smooth_hist[0] = sm;
		k = j - d;
		if (k < 0) return;
		mv = (longint'(att_num) * longint'($signed(smooth_hist[0]))
			- 64 * longint'($signed(smooth_hist[d]))) / 64;
		m = $signed(mv[15:0]);
		if (m > mon_max) begin
			armed = 1'b1;
			mon_max = m;
		end else if (k > 0 && armed && m < 0) begin
			den = longint'(prev_mon) - m;
			t = 0;
			armed = 1'b0;
			if (den != 0)
				t = (k - 1) * step_num + (longint'(prev_mon) * step_num) / den;
			cross_time = t[21:0];
			found = 1'b1;
		end
		prev_mon = m;
	endfunction

	function automatic void predict_timing(logic [15:0] smp, bit last, logic [4:0] rem);
		cfd_result_t r;
		if (n_samples < MAX_SAMPLES) take_sample(smp);
		if (!last) return;
		r.cfd_time = {rem, found ? cross_time : 22'd0};
		r.found = found;
		pending_results.push_back(r);
		clear_waveform();
	endfunction

	// receiver: check results, stall at random or for a hold-off
	always @(posedge clk) begin
		cfd_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result time=%h found=%b", $time,
					m_axis_tdata[26:0], m_axis_tuser[0]);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tdata[26:0] !== exp_r.cfd_time) begin
					$display("%0t: cfd_time expected %h actual %h", $time,
						exp_r.cfd_time, m_axis_tdata[26:0]);
					errors++;
				end
				if (m_axis_tuser[0] !== exp_r.found) begin
					$display("%0t: crossing_found expected %b actual %b", $time,
						exp_r.found, m_axis_tuser[0]);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(logic [15:0] smp, bit last, logic [4:0] rem);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, rem, smp};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_timing(smp, last, rem);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ATT:  att_num = value & 7'h7f;
			REG_DLY:  dly_num = value & 5'h1f;
			REG_HW:   hw_num = value & 4'hf;
			REG_STEP: step_num = value & 11'h7ff;
		endcase
	endtask

	task automatic set_config(int att, int dly, int hw, int steps);
		write_reg(REG_ATT, att);
		write_reg(REG_DLY, dly);
		write_reg(REG_HW, hw);
		write_reg(REG_STEP, steps);
	endtask

	// pulse on a noisy baseline, or plain noise
	task automatic send_waveform(int len, bit noise_only);
		int p, rise, fall, amp, base, v;
		p = $urandom_range(0, len / 2);
		rise = $urandom_range(1, 6);
		fall = $urandom_range(4, 30);
		amp = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40000) - 20000
			: $urandom_range(200, 6000);
		base = $urandom_range(0, 200) - 100;
		for (int i = 0; i < len; i++) begin
			if (noise_only) v = $urandom_range(0, 65535);
			else if (i < p) v = base;
			else if (i < p + rise) v = base + amp * (i - p + 1) / rise;
			else if (i < p + rise + fall) v = base + amp * (p + rise + fall - i) / fall;
			else v = base;
			if (!noise_only) v += $urandom_range(0, 16) - 8;
			send_request(v[15:0], i == len - 1, 5'($urandom_range(0, 31)));
		end
	endtask

	task automatic random_config();
		set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(10, 50),
			$urandom_range(1, MAX_DELAY), $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0,
			$urandom_range(1, 1024));
	endtask

	task automatic test_directed();
		send_request(16'h7fff, 1'b1, 5'd31);
		send_request(16'h8000, 1'b1, 5'd0);
		send_request(16'h0000, 1'b0, 5'd0);
		send_request(16'h7fff, 1'b1, 5'd21);
		send_waveform(20, 1'b0);
		set_config(64, 1, 8, 1024);
		send_waveform(20, 1'b0);
		set_config(0, MAX_DELAY, 0, 1);
		send_waveform(20, 1'b0);
		set_config(24, 8, 0, 256);
	endtask

	task automatic test_random(int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			int len;
			if ($urandom_range(0, 3) == 0) random_config();
			len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 4) : $urandom_range(12, 60);
			send_waveform(len, $urandom_range(0, 9) == 0);
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		hold_cycles <= 400;
		for (int w = 0; w < 30; w++) send_waveform($urandom_range(1, 5), 1'b0);
	endtask

	initial begin
		att_num = ATT_RST;
		dly_num = DLY_RST;
		hw_num = HW_RST;
		step_num = STEP_RST;
		clear_waveform();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 7;
		recv_idle_pct = 70;
		test_random(400);
		send_idle_pct = 70;
		recv_idle_pct = 7;
		test_random(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random(400);
		drain();
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
